FILE: hw/rtl/mpcq_pkg.sv
// shared types and constants for the multicast priority call queues
// depends on nothing
package mpcq_pkg;
    localparam int QUEUE_DEPTH  = 64;
    localparam int SERVED_LIMIT = 64;
    localparam int NUM_DEST     = 3;
    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SRV_W  = $clog2(SERVED_LIMIT + 1);
    localparam int ADDR_W = $clog2(NUM_DEST * QUEUE_DEPTH);

    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_SERVE    = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [1:0]  pri;
        logic [1:0]  line;
        logic        zone;
        logic        backup;
    } call_rec_t;
endpackage

FILE: hw/rtl/mpcq_store.sv
// call record memory, one write port and one registered read port
// depends on mpcq_pkg
module mpcq_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [mpcq_pkg::ADDR_W-1:0] wr_addr,
    input  mpcq_pkg::call_rec_t         wr_data,
    input  logic [mpcq_pkg::ADDR_W-1:0] rd_addr,
    output mpcq_pkg::call_rec_t         rd_data
);
    mpcq_pkg::call_rec_t mem [mpcq_pkg::NUM_DEST * mpcq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hw/rtl/multicast_priority_call_queues_top.sv
// top level: request decode, insert/remove sequencer, counters, result register
// depends on mpcq_pkg and mpcq_store
//
//  channel | direction | beat contents
//  in      | input     | req_type .. dest_index, valid/stall
//  out     | output    | reply_kind .. served_total, valid/stall
//
// register: ST_QSEL picks each selected queue in turn, then per compared entry
//   ST_IRD reads one and ST_ICMP compares, then writes it one slot up or places the call
// serve: the front read is issued with the accepted beat, ST_PRD takes it, then ST_PSHIFT
//   shifts each remaining entry down one slot
// the single memory port pair allows one read and one write per step
// reset clears counters and the fsm; stored records need no clearing
// input stall is high while an item is in work or a result waits; output holds when stalled
module multicast_priority_call_queues_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [1:0]  call_priority,
    input  logic [2:0]  dest_mask,
    input  logic        is_international,
    input  logic [1:0]  phone_line,
    input  logic        zone_flag,
    input  logic        needs_backup,
    input  logic [1:0]  dest_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reply_kind,
    output logic        ok,
    output logic [31:0] call_id,
    output logic [2:0]  enqueued_mask,
    output logic [1:0]  out_priority,
    output logic [1:0]  out_line,
    output logic        out_zone,
    output logic        out_backup,
    output logic [6:0]  served_total
);
    localparam int PW = mpcq_pkg::POS_W;
    localparam int CW = mpcq_pkg::CNT_W;
    localparam int SW = mpcq_pkg::SRV_W;
    localparam int AW = mpcq_pkg::ADDR_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_QSEL   = 7'b0000010,  // pick next queue of the mask
        ST_IRD    = 7'b0000100,  // insert: read entry at pos-1
        ST_ICMP   = 7'b0001000,  // insert: compare, shift up or place
        ST_PRD    = 7'b0010000,  // serve: front data valid, next read issued
        ST_PSHIFT = 7'b0100000,  // serve: shift data valid, write down
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]         id_reg;
    logic [CW-1:0]       qcnt_reg [mpcq_pkg::NUM_DEST];
    logic [SW-1:0]       srv_reg  [mpcq_pkg::NUM_DEST];
    mpcq_pkg::call_rec_t call_reg;
    logic [2:0]          mask_reg;
    logic [2:0]          took_reg;
    logic [1:0]          q_reg;
    logic [CW-1:0]       pos_reg;
    logic                kind_reg;
    logic                ok_reg;

    // memory
    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    mpcq_pkg::call_rec_t wr_data, rd_data;

    mpcq_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [AW-1:0] addr_of(input logic [1:0] q, input logic [PW-1:0] p);
        logic [AW+1:0] a;
        a = (AW+2)'(q) * (AW+2)'(mpcq_pkg::QUEUE_DEPTH) + (AW+2)'(p);
        return a[AW-1:0];
    endfunction

    logic [1:0] qsel;
    always_comb
    begin
        if (mask_reg[0])      qsel = 2'd0;
        else if (mask_reg[1]) qsel = 2'd1;
        else                  qsel = 2'd2;
    end

    logic [CW-1:0] cur_cnt;
    assign cur_cnt = qcnt_reg[q_reg];

    // first compare at position 0 (empty queue) must place: pri compare uses stale data,
    // so an empty-queue insert forces placement through pos_reg==0
    logic shift_up;
    assign shift_up = (rd_data.pri > call_reg.pri) && (pos_reg != '0);

    assign in_stall = (state_reg != ST_IDLE);

    // memory port drive
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_of(q_reg, pos_reg[PW-1:0]);
        wr_data = call_reg;
        rd_addr = addr_of(q_reg, pos_reg[PW-1:0] - PW'(1));
        case (state_reg)
            ST_IDLE:
            begin
                // front of the requested queue, valid in the next cycle
                rd_addr = addr_of(dest_index, '0);
            end
            ST_ICMP:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    wr_data = rd_data;
                end
            end
            ST_PRD:
            begin
                rd_addr = addr_of(q_reg, pos_reg[PW-1:0] + PW'(1));
            end
            ST_PSHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(q_reg, pos_reg[PW-1:0] - PW'(1));
                wr_data = rd_data;
                rd_addr = addr_of(q_reg, pos_reg[PW-1:0] + PW'(1));
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == mpcq_pkg::REQ_REGISTER)
                        state_next = is_international ? ST_DONE : ST_QSEL;
                    else if (dest_index == 2'd3)
                        state_next = ST_DONE;
                    else
                        state_next = ST_PRD;
                end
            end
            ST_QSEL:
            begin
                if (mask_reg == 3'd0)
                    state_next = ST_DONE;
                else if (qcnt_reg[qsel] >= CW'(mpcq_pkg::QUEUE_DEPTH))
                    state_next = ST_QSEL;
                else if (qcnt_reg[qsel] == '0)
                    state_next = ST_ICMP;
                else
                    state_next = ST_IRD;
            end
            ST_IRD:
                state_next = ST_ICMP;
            ST_ICMP:
            begin
                if (shift_up && pos_reg > CW'(1))
                    state_next = ST_IRD;
                else if (shift_up)
                    state_next = ST_ICMP;
                else
                    state_next = ST_QSEL;
            end
            ST_PRD:
            begin
                if (cur_cnt <= CW'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_PSHIFT;
            end
            ST_PSHIFT:
            begin
                // count already holds the size after removal
                if (pos_reg >= cur_cnt)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            id_reg    <= '0;
            for (int i = 0; i < mpcq_pkg::NUM_DEST; i++)
            begin
                qcnt_reg[i] <= '0;
                srv_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && req_type == mpcq_pkg::REQ_REGISTER && !is_international)
                        id_reg <= id_reg + 32'd1;
                end
                ST_ICMP:
                begin
                    if (!shift_up)
                        qcnt_reg[q_reg] <= cur_cnt + CW'(1);
                end
                ST_PRD:
                begin
                    if (cur_cnt != '0)
                    begin
                        qcnt_reg[q_reg] <= cur_cnt - CW'(1);
                        if (srv_reg[q_reg] < SW'(mpcq_pkg::SERVED_LIMIT))
                            srv_reg[q_reg] <= srv_reg[q_reg] + SW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and sequencing registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                kind_reg    <= req_type;
                call_reg.id <= id_reg + 32'd1;
                call_reg.pri    <= call_priority;
                call_reg.line   <= phone_line;
                call_reg.zone   <= zone_flag;
                call_reg.backup <= needs_backup;
                mask_reg <= dest_mask;
                took_reg <= '0;
                q_reg    <= dest_index;
                pos_reg  <= '0;
                ok_reg   <= (req_type == mpcq_pkg::REQ_REGISTER) ? !is_international : 1'b0;
                if (req_type == mpcq_pkg::REQ_REGISTER && is_international)
                    call_reg.id <= '0;
            end
            ST_QSEL:
            begin
                if (mask_reg != 3'd0)
                begin
                    mask_reg[qsel] <= 1'b0;
                    q_reg   <= qsel;
                    pos_reg <= qcnt_reg[qsel];
                    if (qcnt_reg[qsel] < CW'(mpcq_pkg::QUEUE_DEPTH))
                        took_reg[qsel] <= 1'b1;
                end
            end
            ST_ICMP:
            begin
                if (shift_up)
                    pos_reg <= pos_reg - CW'(1);
            end
            ST_PRD:
            begin
                pos_reg <= CW'(1);
                if (cur_cnt != '0)
                begin
                    ok_reg   <= 1'b1;
                    call_reg <= rd_data;
                end
            end
            ST_PSHIFT:
                pos_reg <= pos_reg + CW'(1);
            default:
            begin
            end
        endcase
    end

    // ST_ICMP with pos 0 may read a stale word; shift_up guards it. After a shift
    // the next compare at pos 0 comes straight from ST_ICMP only when pos was 1
    // before; rd_data is then stale but need not be refreshed
    // (state_next picks ST_ICMP only when pos_reg<=1, where shift_up
    // then sees pos 0 and places)

    logic serve_bad;
    assign serve_bad = (kind_reg == mpcq_pkg::REQ_SERVE) && (q_reg == 2'd3);

    assign out_valid     = (state_reg == ST_DONE);
    assign reply_kind    = kind_reg;
    assign ok            = ok_reg;
    assign call_id       = (kind_reg == mpcq_pkg::REQ_SERVE && !ok_reg) ? '0 : call_reg.id;
    assign enqueued_mask = (kind_reg == mpcq_pkg::REQ_SERVE || !ok_reg) ? 3'd0 : took_reg;
    assign out_priority  = (kind_reg == mpcq_pkg::REQ_SERVE && ok_reg) ? call_reg.pri : 2'd0;
    assign out_line      = (kind_reg == mpcq_pkg::REQ_SERVE && ok_reg) ? call_reg.line : 2'd0;
    assign out_zone      = (kind_reg == mpcq_pkg::REQ_SERVE && ok_reg) && call_reg.zone;
    assign out_backup    = (kind_reg == mpcq_pkg::REQ_SERVE && ok_reg) && call_reg.backup;
    assign served_total  = (kind_reg == mpcq_pkg::REQ_SERVE && !serve_bad)
                         ? 7'(srv_reg[q_reg[1] ? 2 : (q_reg[0] ? 1 : 0)]) : 7'd0;

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(call_id) && $stable(ok)))
        else $error("result changed while stalled");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (qcnt_reg[0] <= CW'(mpcq_pkg::QUEUE_DEPTH)) && (qcnt_reg[1] <= CW'(mpcq_pkg::QUEUE_DEPTH))
        && (qcnt_reg[2] <= CW'(mpcq_pkg::QUEUE_DEPTH)))
        else $error("queue count overflow");
    a_srv_sat: assert property (@(posedge clk) disable iff (!rst_n)
        srv_reg[0] <= SW'(mpcq_pkg::SERVED_LIMIT))
        else $error("served count above limit");
`endif
endmodule

FILE: tb/multicast_priority_call_queues_top_tb.sv
// self-checking testbench for the multicast priority call queues
// depends on mpcq_pkg and the multicast_priority_call_queues_top rtl
module multicast_priority_call_queues_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = mpcq_pkg::REQ_REGISTER;
    logic [1:0]  call_priority = '0;
    logic [2:0]  dest_mask = '0;
    logic        is_international = 1'b0;
    logic [1:0]  phone_line = '0;
    logic        zone_flag = 1'b0;
    logic        needs_backup = 1'b0;
    logic [1:0]  dest_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        reply_kind;
    logic        ok;
    logic [31:0] call_id;
    logic [2:0]  enqueued_mask;
    logic [1:0]  out_priority;
    logic [1:0]  out_line;
    logic        out_zone;
    logic        out_backup;
    logic [6:0]  served_total;

    // one request beat
    typedef struct packed {
        logic        kind;
        logic [1:0]  pri;
        logic [2:0]  mask;
        logic        intl;
        logic [1:0]  line;
        logic        zone;
        logic        backup;
        logic [1:0]  dest;
    } call_req_t;

    // one reply beat
    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [31:0] id;
        logic [2:0]  took;
        logic [1:0]  pri;
        logic [1:0]  line;
        logic        zone;
        logic        backup;
        logic [6:0]  served;
    } call_reply_t;

    // directed row: request plus an optional typed-in reply
    typedef struct packed {
        call_req_t   req;
        logic        has_fixed;
        call_reply_t fixed;
    } dir_row_t;

    multicast_priority_call_queues_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: per-destination sorted lists, numbering counter, served counts
    mpcq_pkg::call_rec_t dest_queue [mpcq_pkg::NUM_DEST][$];
    logic [31:0] next_number;
    int          served_cnt [mpcq_pkg::NUM_DEST];
    call_reply_t pending_replies [$];
    int          error_count = 0;
    int          idle_cycles = 0;

    function automatic call_reply_t predict_reply(call_req_t r);
        call_reply_t rep;
        mpcq_pkg::call_rec_t c;
        int          pos;
        rep = '0;
        rep.kind = r.kind;
        if (r.kind == mpcq_pkg::REQ_REGISTER)
        begin
            if (r.intl)
                return rep;
            next_number = next_number + 32'd1;
            c.id = next_number;
            c.pri = r.pri;
            c.line = r.line;
            c.zone = r.zone;
            c.backup = r.backup;
            for (int q = 0; q < mpcq_pkg::NUM_DEST; q++)
            begin
                if (r.mask[q] && dest_queue[q].size() < mpcq_pkg::QUEUE_DEPTH)
                begin
                    // stable insert: behind every entry of equal or higher urgency
                    pos = dest_queue[q].size();
                    while (pos > 0 && dest_queue[q][pos-1].pri > c.pri)
                        pos--;
                    dest_queue[q].insert(pos, c);
                    rep.took[q] = 1'b1;
                end
            end
            rep.ok = 1'b1;
            rep.id = c.id;
        end
        else
        begin
            if (r.dest >= mpcq_pkg::NUM_DEST)
                return rep;
            if (dest_queue[r.dest].size() > 0)
            begin
                c = dest_queue[r.dest].pop_front();
                rep.ok = 1'b1;
                rep.id = c.id;
                rep.pri = c.pri;
                rep.line = c.line;
                rep.zone = c.zone;
                rep.backup = c.backup;
                if (served_cnt[r.dest] < mpcq_pkg::SERVED_LIMIT)
                    served_cnt[r.dest]++;
            end
            rep.served = 7'(served_cnt[r.dest]);
        end
        return rep;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // most gaps short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic send_request(call_req_t r, logic has_fixed, call_reply_t fixed);
        call_reply_t want;
        int          g;
        g = gap_len();
        repeat (g) @(negedge clk);
        req_type = r.kind;
        call_priority = r.pri;
        dest_mask = r.mask;
        is_international = r.intl;
        phone_line = r.line;
        zone_flag = r.zone;
        needs_backup = r.backup;
        dest_index = r.dest;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // beat accepted at this edge
        want = predict_reply(r);
        if (has_fixed && want != fixed)
            report_mismatch("typed-in reply vs predictor", 32'(want.id), 32'(fixed.id));
        pending_replies.push_back(want);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic call_req_t random_request();
        call_req_t r;
        r = call_req_t'($urandom);
        // registers slightly outnumber serves so queues fill
        r.kind = ($urandom_range(99) < 55) ? mpcq_pkg::REQ_REGISTER : mpcq_pkg::REQ_SERVE;
        r.intl = ($urandom_range(9) == 0);
        return r;
    endfunction

    // output sink: random stall, compare every reply beat
    always @(posedge clk)
    begin
        call_reply_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("reply with nothing pending", call_id, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (reply_kind !== want.kind)
                    report_mismatch("reply_kind", 32'(reply_kind), 32'(want.kind));
                if (ok !== want.ok)
                    report_mismatch("ok", 32'(ok), 32'(want.ok));
                if (call_id !== want.id)
                    report_mismatch("call_id", call_id, want.id);
                if (enqueued_mask !== want.took)
                    report_mismatch("enqueued_mask", 32'(enqueued_mask), 32'(want.took));
                if (out_priority !== want.pri)
                    report_mismatch("out_priority", 32'(out_priority), 32'(want.pri));
                if (out_line !== want.line)
                    report_mismatch("out_line", 32'(out_line), 32'(want.line));
                if (out_zone !== want.zone)
                    report_mismatch("out_zone", 32'(out_zone), 32'(want.zone));
                if (out_backup !== want.backup)
                    report_mismatch("out_backup", 32'(out_backup), 32'(want.backup));
                if (served_total !== want.served)
                    report_mismatch("served_total", 32'(served_total), 32'(want.served));
            end
        end
    end

    // stall pattern: runs of stall and free of random length, sometimes none
    initial
    begin
        int n;
        forever
        begin
            n = gap_len();
            out_stall = (n != 0);
            repeat (n) @(negedge clk);
            out_stall = 1'b0;
            repeat ($urandom_range(20, 1)) @(negedge clk);
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic call_req_t mk_req(logic kind, logic [1:0] pri, logic [2:0] mask,
                                         logic intl, logic [1:0] line, logic zone,
                                         logic backup, logic [1:0] dest);
        call_req_t r;
        r.kind = kind; r.pri = pri; r.mask = mask; r.intl = intl;
        r.line = line; r.zone = zone; r.backup = backup; r.dest = dest;
        return r;
    endfunction

    function automatic call_reply_t mk_rep(logic kind, logic okv, logic [31:0] id,
                                           logic [2:0] took, logic [6:0] served);
        call_reply_t p;
        p = '0;
        p.kind = kind; p.ok = okv; p.id = id; p.took = took; p.served = served;
        return p;
    endfunction

    dir_row_t directed_rows [$];

    initial
    begin
        call_req_t r;
        next_number = '0;
        for (int q = 0; q < mpcq_pkg::NUM_DEST; q++)
            served_cnt[q] = 0;

        // directed table; typed-in replies only where obvious
        // empty serve on each queue, then the ignored destination index
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0, 0, 0, 2), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_SERVE, 3, 7, 1, 3, 1, 1, 3), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0)});
        // international rejected, no number consumed
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 0, 7, 1, 3, 1, 1, 0), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_REGISTER, 0, 0, 0, 0)});
        // first numbers, mask zero still numbered
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 2, 7, 0, 0, 0, 0, 0), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_REGISTER, 1, 1, 7, 0)});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 1, 0, 0, 1, 1, 0, 0), 1'b1,
                                  mk_rep(mpcq_pkg::REQ_REGISTER, 1, 2, 0, 0)});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 3, 5, 0, 3, 1, 1, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 0, 3, 0, 2, 0, 1, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 2, 6, 0, 1, 1, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 0, 1, 0, 0, 0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 1, 2, 0, 3, 0, 1, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(mpcq_pkg::REQ_REGISTER, 1, 4, 0, 2, 1, 1, 0),
                                  1'b0, '0});
        // drain in priority order, ties oldest first
        for (int i = 0; i < 4; i++)
            for (int q = 0; q < 3; q++)
                directed_rows.push_back('{mk_req(mpcq_pkg::REQ_SERVE, 0, 0, 0, 0, 0, 0, 2'(q)),
                                          1'b0, '0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_fixed,
                         directed_rows[i].fixed);

        // fill every queue past full with well-formed multicast calls
        for (int i = 0; i < 70; i++)
        begin
            r = random_request();
            r.kind = mpcq_pkg::REQ_REGISTER;
            r.intl = 1'b0;
            r.mask = 3'b111;
            send_request(r, 1'b0, '0);
        end
        // hold off until every reply is back
        wait (pending_replies.size() == 0);
        // drain past empty so served counts saturate
        for (int i = 0; i < 200; i++)
        begin
            r = random_request();
            r.kind = mpcq_pkg::REQ_SERVE;
            r.dest = 2'($urandom_range(2));
            send_request(r, 1'b0, '0);
        end
        for (int i = 0; i < 430; i++)
            send_request(random_request(), 1'b0, '0);

        wait (pending_replies.size() == 0);
        repeat (500) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/mpcq_pkg.sv
hw/rtl/mpcq_store.sv
hw/rtl/multicast_priority_call_queues_top.sv
tb/multicast_priority_call_queues_top_tb.sv
